[sv/smpq_pkg.sv]
package smpq_pkg;

    localparam int CAPACITY  = 64;
    localparam int KEY_WIDTH = 16;

    localparam int FIELD_W = 16;
    localparam int ENTRY_W = KEY_WIDTH + FIELD_W;
    localparam int ADDR_W  = $clog2(CAPACITY);
    localparam int CNT_W   = $clog2(CAPACITY + 1);

    localparam logic KIND_INSERT  = 1'b0;
    localparam logic KIND_EXTRACT = 1'b1;

    typedef enum logic [1:0] {
        ST_INSERTED  = 2'd0,
        ST_EXTRACTED = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef struct packed {
        logic                      kind;
        logic signed [FIELD_W-1:0] key;
        logic        [FIELD_W-1:0] payload;
    } t_in_item;

    typedef struct packed {
        t_status                   status;
        logic signed [FIELD_W-1:0] out_key;
        logic        [FIELD_W-1:0] out_payload;
    } t_out_item;

    // low KEY_WIDTH bits of the port key; zero above bit 15 for wide keys
    function automatic logic signed [KEY_WIDTH-1:0] to_key(input logic [FIELD_W-1:0] raw);
        logic signed [KEY_WIDTH-1:0] r;
        r = '0;
        for (int b = 0; b < KEY_WIDTH; b++) begin
            if (b < FIELD_W) begin
                r[b] = raw[b];
            end
        end
        return r;
    endfunction

    // back to port width: sign-extend narrow keys, truncate wide ones
    function automatic logic signed [FIELD_W-1:0] from_key(input logic signed [KEY_WIDTH-1:0] k);
        logic signed [FIELD_W-1:0] r;
        r = '0;
        for (int b = 0; b < FIELD_W; b++) begin
            if (b < KEY_WIDTH) begin
                r[b] = k[b];
            end else begin
                r[b] = k[KEY_WIDTH-1];
            end
        end
        return r;
    endfunction

endpackage

[sv/stable_max_priority_queue.sv]
// Channel  | Valid        | Ready        | Payload               | Meaning
// ---------+--------------+--------------+-----------------------+---------------------------
// input    | i_in_valid   | o_in_ready   | i_in  (t_in_item)     | insert or extract-max item
// output   | o_out_valid  | i_out_ready  | o_out (t_out_item)    | one result item per input
//
// Insert: accept (memory write unless full), then result load.
// Extract from N entries: accept, read all N entries to find the max, move the M entries behind
// the winner down by one (none if M is 0), then result load; an empty queue skips to result load.
// The entry memory has a single read port, which both the scan and the shift use.
// Reset clears the fill count and the control only; the memory holds garbage until written.
// The result sits in an output register; a stalled output only holds the next result back.
module stable_max_priority_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  smpq_pkg::t_in_item   i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output smpq_pkg::t_out_item  o_out
);

    import smpq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,   // walk entries 0..count-1, keep the first largest key
        S_SHIFT,  // move entries behind the winner down by one
        S_DONE    // hand the result to the output register
    } t_state;

    t_state                      r_state;
    logic [CNT_W-1:0]            r_count;
    logic [CNT_W-1:0]            r_rd_idx;
    logic                        r_issue;     // reads still to issue
    logic                        r_cmp_vld;   // read data returns this cycle
    logic [ADDR_W-1:0]           r_cmp_idx;   // scan: address of returned data; shift: target
    logic signed [KEY_WIDTH-1:0] r_best_key;
    logic [FIELD_W-1:0]          r_best_pay;
    logic [ADDR_W-1:0]           r_best_idx;
    t_out_item                   r_res;
    t_out_item                   r_out;
    logic                        r_out_vld;

    logic                        w_in_fire;
    logic                        w_out_free;
    logic                        w_full;
    t_status                     w_idle_status;
    logic                        w_re;
    logic [ADDR_W-1:0]           w_raddr;
    logic                        w_we;
    logic [ADDR_W-1:0]           w_waddr;
    logic [ENTRY_W-1:0]          w_wdata;
    logic [ENTRY_W-1:0]          w_rdata;
    logic signed [KEY_WIDTH-1:0] w_rd_key;
    logic [FIELD_W-1:0]          w_rd_pay;
    logic [CNT_W-1:0]            w_rd_next;
    logic [CNT_W-1:0]            w_rd_prev;
    logic                        w_take;
    logic signed [KEY_WIDTH-1:0] n_best_key;
    logic [FIELD_W-1:0]          n_best_pay;
    logic [ADDR_W-1:0]           n_best_idx;
    logic [CNT_W-1:0]            w_shift_start;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_in_fire   = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_vld || i_out_ready;
    assign w_full      = (r_count == CNT_W'(CAPACITY));
    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

    // status of an item that finishes straight from idle
    assign w_idle_status = (i_in.kind == KIND_INSERT) ? (w_full ? ST_FULL : ST_INSERTED) :
                           ((r_count == '0) ? ST_EMPTY : ST_EXTRACTED);

    assign w_rd_key  = w_rdata[ENTRY_W-1:FIELD_W];
    assign w_rd_pay  = w_rdata[FIELD_W-1:0];
    assign w_rd_next = r_rd_idx + CNT_W'(1);
    assign w_rd_prev = r_rd_idx - CNT_W'(1);

    // first entry seeds the max; later ones replace it only when strictly larger
    assign w_take     = (r_cmp_idx == '0) || (w_rd_key > r_best_key);
    assign n_best_key = w_take ? w_rd_key  : r_best_key;
    assign n_best_pay = w_take ? w_rd_pay  : r_best_pay;
    assign n_best_idx = w_take ? r_cmp_idx : r_best_idx;
    assign w_shift_start = CNT_W'(n_best_idx) + CNT_W'(1);

    // memory port steering
    always_comb begin
        w_re    = 1'b0;
        w_raddr = r_rd_idx[ADDR_W-1:0];
        w_we    = 1'b0;
        w_waddr = r_count[ADDR_W-1:0];
        w_wdata = {to_key(i_in.key), i_in.payload};
        unique case (r_state)
            S_IDLE: begin
                w_we = w_in_fire && (i_in.kind == KIND_INSERT) && !w_full;
            end
            S_SCAN: begin
                w_re = r_issue;
            end
            S_SHIFT: begin
                w_re    = r_issue;
                w_we    = r_cmp_vld;
                w_waddr = r_cmp_idx;
                w_wdata = w_rdata;
            end
            S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    smpq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_issue   <= 1'b0;
            r_cmp_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            // output register: loads from S_DONE, drains independently of the core
            if (r_state == S_DONE && w_out_free) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_in_fire) begin
                        r_res <= '{status: w_idle_status, out_key: '0, out_payload: '0};
                        if (i_in.kind == KIND_INSERT) begin
                            if (!w_full) begin
                                r_count <= r_count + CNT_W'(1);
                            end
                            r_state <= S_DONE;
                        end else if (r_count == '0) begin
                            r_state <= S_DONE;
                        end else begin
                            r_rd_idx  <= '0;
                            r_issue   <= 1'b1;
                            r_cmp_vld <= 1'b0;
                            r_state   <= S_SCAN;
                        end
                    end
                end

                S_SCAN: begin
                    if (r_issue) begin
                        r_cmp_vld <= 1'b1;
                        r_cmp_idx <= r_rd_idx[ADDR_W-1:0];
                        r_rd_idx  <= w_rd_next;
                        if (w_rd_next == r_count) begin
                            r_issue <= 1'b0;
                        end
                    end else begin
                        r_cmp_vld <= 1'b0;
                    end
                    if (r_cmp_vld) begin
                        r_best_key <= n_best_key;
                        r_best_pay <= n_best_pay;
                        r_best_idx <= n_best_idx;
                    end
                    // last read data just came back: winner is known
                    if (r_cmp_vld && !r_issue) begin
                        r_res <= '{status:      ST_EXTRACTED,
                                   out_key:     from_key(n_best_key),
                                   out_payload: n_best_pay};
                        if (w_shift_start == r_count) begin
                            // winner was the newest entry, nothing to move
                            r_count <= r_count - CNT_W'(1);
                            r_state <= S_DONE;
                        end else begin
                            r_rd_idx <= w_shift_start;
                            r_issue  <= 1'b1;
                            r_state  <= S_SHIFT;
                        end
                    end
                end

                S_SHIFT: begin
                    // read j+1 now, write it to j next cycle; never the same entry
                    if (r_issue) begin
                        r_cmp_vld <= 1'b1;
                        r_cmp_idx <= w_rd_prev[ADDR_W-1:0];
                        r_rd_idx  <= w_rd_next;
                        if (w_rd_next == r_count) begin
                            r_issue <= 1'b0;
                        end
                    end else begin
                        r_cmp_vld <= 1'b0;
                    end
                    if (r_cmp_vld && !r_issue) begin
                        r_count <= r_count - CNT_W'(1);
                        r_state <= S_DONE;
                    end
                end

                S_DONE: begin
                    if (w_out_free) begin
                        r_out   <= r_res;
                        r_state <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[sv/smpq_ram.sv]
module smpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
